/* rtl/core/lrf_pkg.sv */
// Package for the folded linear congruential random source.
// Holds the request codes, the multiplier constants and the fold functions.
// Depends on nothing; lrf_mod and lcg_random_folded_unit use it by scoped names.
`default_nettype none

package lrf_pkg;

	typedef enum logic [1:0] {
		REQ_RESEED  = 2'd0,
		REQ_V15     = 2'd1,
		REQ_BYTE    = 2'd2,
		REQ_BOUNDED = 2'd3
	} req_kind_t;

	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned SEED_W   = 32;
	localparam int unsigned VALUE_W  = 15;
	localparam int unsigned BOUND_W  = 16;
	localparam int unsigned K_W      = 21;
	localparam int unsigned PROD_W   = K_W + DIGIT_W;
	localparam int unsigned N_DIGITS = SEED_W / DIGIT_W;

	localparam logic [K_W-1:0]    STEP_MUL   = 21'd1664525;
	localparam logic [K_W-1:0]    RESEED_MUL = 21'd69069;
	localparam logic [SEED_W-1:0] STEP_ADD   = 32'd221297;

	// Status of the serial remainder unit, seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

	// Low 15 bits plus bits 15..29 plus bit 31, then an end-around carry.
	function automatic logic [14:0] fold15(input logic [31:0] s);
		logic [15:0] r;
		logic [14:0] f;
		r = 16'(s[14:0]) + 16'(s[29:15]) + 16'(s[31]);
		f = r[14:0] + 15'(r[15]);
		return f;
	endfunction

	// Overlapping byte fold: low byte, bits 7..14 and bits 15..31.
	function automatic logic [7:0] fold8(input logic [31:0] s);
		logic [17:0] r;
		logic [10:0] t;
		r = 18'(s[7:0]) + 18'(s[14:7]) + 18'(s[31:15]);
		t = 11'(r[7:0]) + r[17:7];
		return t[7:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/lrf_req_if.sv */
// Request channel of the random source: valid/ready plus the request word.
// Depends on nothing.
`default_nettype none

interface lrf_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] seed_value;
	logic [15:0]        bound;

	modport source(output valid, output req_type, output seed_value, output bound,
		input ready);
	modport sink(input valid, input req_type, input seed_value, input bound,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/lrf_rsp_if.sv */
// Response channel of the random source: valid/ready plus the 15-bit value.
// Depends on nothing.
`default_nettype none

interface lrf_rsp_if;
	logic        valid;
	logic        ready;
	logic [14:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

`default_nettype wire

/* rtl/core/lrf_mod.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on lrf_pkg.
`default_nettype none

module lrf_mod (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [14:0]       dividend,
	input  wire logic [15:0]       divisor,
	output lrf_pkg::mod_stat_t     stat,
	output logic [14:0]            rem
);

	logic [15:0] r_q;
	logic [14:0] dv_q;
	logic [15:0] d_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;

	assign trial = {r_q, dv_q[14]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(lrf_pkg::VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= '0;
			dv_q <= dividend;
			d_q  <= divisor;
		end else if (busy_q) begin
			dv_q <= {dv_q[13:0], 1'b0};
			r_q  <= ge ? diff[15:0] : trial[15:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = r_q[14:0];

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("remainder unit restarted while busy");
	a_done_rem: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (r_q < d_q)) else $error("remainder not below divisor");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a running division");

endmodule

`default_nettype wire

/* rtl/core/lcg_random_folded_unit.sv */
// Flow: a reseed, fifteen-bit or byte request passes the multiply, fold and done states;
// a bounded request adds the divide state, and a bounded request with a zero bound goes straight to done.
// Throughput: one request at a time; the next is taken once the block is back in idle.
// The seed update runs one 4-bit digit per cycle, the remainder one bit per cycle.
// Reset clears the seed to zero and empties the output register.
// Top level of the folded random source. Depends on lrf_pkg, lrf_req_if, lrf_rsp_if, lrf_mod.
`default_nettype none

module lcg_random_folded_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	lrf_req_if.sink   req,
	lrf_rsp_if.source rsp
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_FOLD = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t              state_q;
	lrf_pkg::req_kind_t  kind_q;
	logic [31:0]         seed_q;
	logic [31:0]         x_q;
	logic [31:0]         acc_q;
	logic [2:0]          cnt_q;
	logic [15:0]         bound_q;
	logic [14:0]         res_q;
	logic [14:0]         value_q;
	logic                out_valid_q;

	lrf_pkg::req_kind_t  req_kind;
	logic                accept;
	logic                load_out;
	logic [20:0]         mul_k;
	logic [24:0]         prod;
	logic [31:0]         acc_next;
	logic [14:0]         f15;
	logic [7:0]          f8;
	logic                mod_start;
	lrf_pkg::mod_stat_t  mod_stat;
	logic [14:0]         mod_rem;

	assign req_kind  = lrf_pkg::req_kind_t'(req.req_type);
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// Horner form: the top digit of the operand enters first, so the partial product
	// shifts up a digit each cycle and the wrap modulo 2^32 comes for free.
	assign mul_k    = (kind_q == lrf_pkg::REQ_RESEED) ? lrf_pkg::RESEED_MUL : lrf_pkg::STEP_MUL;
	assign prod     = 25'(x_q[31:28]) * 25'(mul_k);
	assign acc_next = {acc_q[27:0], 4'b0000} + 32'(prod)
		+ (((cnt_q == 3'(lrf_pkg::N_DIGITS - 1)) && (kind_q != lrf_pkg::REQ_RESEED))
			? lrf_pkg::STEP_ADD : 32'd0);

	assign f15       = lrf_pkg::fold15(seed_q);
	assign f8        = lrf_pkg::fold8(seed_q);
	assign mod_start = (state_q == ST_FOLD) && (kind_q == lrf_pkg::REQ_BOUNDED);

	lrf_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (f15),
		.divisor  (bound_q),
		.stat     (mod_stat),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if ((req_kind == lrf_pkg::REQ_BOUNDED) && (req.bound == 16'd0)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'(lrf_pkg::N_DIGITS - 1)) begin
						seed_q  <= acc_next;
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (kind_q == lrf_pkg::REQ_BOUNDED) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (mod_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req_kind;
			bound_q <= req.bound;
			acc_q   <= '0;
			res_q   <= '0;
			if (req_kind == lrf_pkg::REQ_RESEED) begin
				x_q <= {req.seed_value[30:0], 1'b1};
			end else begin
				x_q <= seed_q;
			end
		end else if (state_q == ST_MUL) begin
			acc_q <= acc_next;
			x_q   <= {x_q[27:0], 4'b0000};
		end else if (state_q == ST_FOLD) begin
			case (kind_q)
				lrf_pkg::REQ_V15:  res_q <= f15;
				lrf_pkg::REQ_BYTE: res_q <= {7'b0000000, f8};
				default:           res_q <= '0;
			endcase
		end else if ((state_q == ST_DIV) && mod_stat.done) begin
			res_q <= mod_rem;
		end
		if (load_out) begin
			value_q <= res_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.value = value_q;

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_stat.done |-> (state_q == ST_DIV)) else $error("remainder finished outside divide");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) && mod_stat.done) |-> (mod_rem < bound_q))
		else $error("bounded word not below its bound");
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FOLD) && (kind_q == lrf_pkg::REQ_BYTE)) |=> (res_q[14:8] == 7'd0))
		else $error("byte word has upper bits set");
	a_seed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != ST_MUL) && $past(state_q != ST_MUL)) |-> $stable(seed_q))
		else $error("seed changed outside the multiply");

endmodule

`default_nettype wire
